// ===== sv/sstf_pkg.sv =====
// Shared constants, result codes and controller/datapath handshake types
// for the SSTF request scheduler. No dependencies.
package sstf_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int SECTOR_BITS = 48;
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef logic [SECTOR_BITS-1:0] sector_type;
   typedef logic [IDX_BITS-1:0]    slot_idx_type;
   typedef logic [1:0]             status_type;
   typedef logic                   opcode_type;

   localparam opcode_type OP_INSERT   = 1'b0;
   localparam opcode_type OP_DISPATCH = 1'b1;

   localparam status_type STATUS_INSERTED   = 2'd0;
   localparam status_type STATUS_DISPATCHED = 2'd1;
   localparam status_type STATUS_EMPTY      = 2'd2;
   localparam status_type STATUS_FULL       = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;      // store the accepted sector in the lowest free slot
      logic scan_start;  // reset the scan index and the running best
      logic scan_issue;  // read one slot and advance the scan index
      logic commit;      // retire the best slot and build the dispatch result
      logic load_out;    // move the pending result into the output register
   } sstf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;   // the slot being read this cycle is the last one
   } sstf_sts_type;

endpackage

// ===== sv/sstf_ifs.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on sstf_pkg.
interface sstf_req_if import sstf_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   sector_type sector;

   modport source (output valid, output opcode, output sector, input ready);
   modport sink   (input valid, input opcode, input sector, output ready);
endinterface

interface sstf_rsp_if import sstf_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   sector_type chosen_sector;

   modport source (output valid, output status, output chosen_sector, input ready);
   modport sink   (input valid, input status, input chosen_sector, output ready);
endinterface

// ===== sv/sstf_request_scheduler_top.sv =====
// Shortest-seek-time-first request scheduler: top level.
// Requests enter on req_chan, one result per request leaves on rsp_chan.
// Opcode insert stores the sector in the lowest free slot (status inserted,
// or full when all TABLE_DEPTH slots are taken). Opcode dispatch removes the
// pending sector nearest the last dispatched one (higher sector on a tie),
// returns it in chosen_sector and makes it the new head; status empty when
// nothing is pending. chosen_sector is zero for every status but dispatched.
// The dispatch time is set by the scan, which reads one slot per cycle
// from the single-port slot store through a two-stage distance/compare
// pipeline. One item is in work at a time; req ready rises in the same
// cycle as rsp valid.
// The output register lets the next item be accepted while the previous
// result is still waiting; if the receiver stalls, a finished result waits
// in the block until the output register is taken.
// Synchronous reset empties the table, sets the head to sector zero and
// drops any pending response.
// Depends on sstf_pkg, sstf_ifs, sstf_controller and sstf_datapath.
module sstf_request_scheduler_top import sstf_pkg::*; (
   input logic          clock,
   input logic          reset,
   sstf_req_if.sink     req_chan,
   sstf_rsp_if.source   rsp_chan
);

   sstf_cmd_type cmd;
   sstf_sts_type sts;

   sstf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   sstf_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_sector        (req_chan.sector),
      .rsp_status        (rsp_chan.status),
      .rsp_chosen_sector (rsp_chan.chosen_sector)
   );

endmodule

// ===== sv/sstf_datapath.sv =====
// Slot table, scan pipeline, head position and result registers.
// Depends on sstf_pkg; driven by sstf_controller through sstf_cmd_type.
module sstf_datapath import sstf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sstf_cmd_type cmd,
   output sstf_sts_type sts,
   input  sector_type   req_sector,
   output status_type   rsp_status,
   output sector_type   rsp_chosen_sector
);

   sector_type                 slot_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]     slot_valid_ff, slot_valid_in;
   sector_type                 head_ff, head_in;

   slot_idx_type               scan_idx_ff, scan_idx_in;

   logic                       s1_vld_ff;
   sector_type                 rd_data_ff;
   slot_idx_type               s1_idx_ff;

   logic                       s2_vld_ff;
   sector_type                 s2_dist_ff, s2_dist_in;
   sector_type                 s2_sec_ff;
   slot_idx_type               s2_idx_ff;

   logic                       best_found_ff, best_found_in;
   sector_type                 best_dist_ff, best_dist_in;
   sector_type                 best_sec_ff, best_sec_in;
   slot_idx_type               best_idx_ff, best_idx_in;

   status_type                 res_status_ff, res_status_in;
   sector_type                 res_sector_ff, res_sector_in;
   status_type                 out_status_ff;
   sector_type                 out_sector_ff;

   logic                       free_any;
   slot_idx_type               free_idx;
   logic [SECTOR_BITS:0]       diff;
   logic                       better;

   // Lowest-numbered free slot.
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_BITS'(i);
         end
      end
   end

   // Exact unsigned distance from the head.
   always_comb begin
      diff = {1'b0, rd_data_ff} - {1'b0, head_ff};
      if (diff[SECTOR_BITS]) begin
         s2_dist_in = head_ff - rd_data_ff;
      end else begin
         s2_dist_in = diff[SECTOR_BITS-1:0];
      end
   end

   // Nearer wins; on equal distance the higher sector wins; equal sectors keep the earlier slot.
   assign better = !best_found_ff || (s2_dist_ff < best_dist_ff) ||
                   ((s2_dist_ff == best_dist_ff) && (s2_sec_ff > best_sec_ff));

   always_comb begin
      best_found_in = best_found_ff;
      best_dist_in  = best_dist_ff;
      best_sec_in   = best_sec_ff;
      best_idx_in   = best_idx_ff;
      if (cmd.scan_start) begin
         best_found_in = 1'b0;
      end else if (s2_vld_ff && better) begin
         best_found_in = 1'b1;
         best_dist_in  = s2_dist_ff;
         best_sec_in   = s2_sec_ff;
         best_idx_in   = s2_idx_ff;
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (cmd.scan_issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      head_in       = head_ff;
      res_status_in = res_status_ff;
      res_sector_in = res_sector_ff;
      if (cmd.insert) begin
         res_sector_in = '0;
         if (free_any) begin
            slot_valid_in[free_idx] = 1'b1;
            res_status_in           = STATUS_INSERTED;
         end else begin
            res_status_in = STATUS_FULL;
         end
      end else if (cmd.commit) begin
         if (best_found_ff) begin
            slot_valid_in[best_idx_ff] = 1'b0;
            head_in                    = best_sec_ff;
            res_status_in              = STATUS_DISPATCHED;
            res_sector_in              = best_sec_ff;
         end else begin
            res_status_in = STATUS_EMPTY;
            res_sector_in = '0;
         end
      end
   end

   // Slot store: written on insert, read one slot per cycle during a scan.
   always_ff @(posedge clock) begin
      if (cmd.insert && free_any) begin
         slot_mem[free_idx] <= req_sector;
      end
      rd_data_ff <= slot_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         head_ff       <= '0;
         scan_idx_ff   <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         head_ff       <= head_in;
         scan_idx_ff   <= scan_idx_in;
         s1_vld_ff     <= cmd.scan_issue && slot_valid_ff[scan_idx_ff];
         s2_vld_ff     <= s1_vld_ff;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff     <= scan_idx_ff;
      s2_dist_ff    <= s2_dist_in;
      s2_sec_ff     <= rd_data_ff;
      s2_idx_ff     <= s1_idx_ff;
      best_dist_ff  <= best_dist_in;
      best_sec_ff   <= best_sec_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_sector_ff <= res_sector_in;
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_sector_ff <= res_sector_ff;
      end
   end

   assign sts.scan_last     = (scan_idx_ff == IDX_BITS'(TABLE_DEPTH - 1));
   assign rsp_status        = out_status_ff;
   assign rsp_chosen_sector = out_sector_ff;

endmodule

// ===== sv/sstf_controller.sv =====
// Sequencer for inserts and dispatch scans, plus the response valid flag.
// Depends on sstf_pkg; commands sstf_datapath.
module sstf_controller import sstf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  opcode_type   req_opcode,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sstf_cmd_type cmd,
   input  sstf_sts_type sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN1 = 3'd2;
   localparam logic [2:0] S_DRAIN2 = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_DISPATCH) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.insert = 1'b1;
                  state_in   = S_DONE;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN1;
            end
         end
         S_DRAIN1: state_in = S_DRAIN2;
         S_DRAIN2: state_in = S_COMMIT;
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_dispatch_scans: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_opcode == OP_DISPATCH) |=> (state_ff == S_SCAN))
      else $error("dispatch did not start a scan");

   a_insert_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_opcode == OP_INSERT) |=> (state_ff == S_DONE))
      else $error("insert did not go straight to result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("stalled response overwritten");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.scan_last) |=> (state_ff == S_DRAIN1))
      else $error("scan did not end after last slot");

   a_commit_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |=> (state_ff == S_DONE && !req_ready))
      else $error("commit not followed by result stage");

endmodule
